FILE: rtl/sliding_window_hit_voter_top_macros.svh
// Assertion macros for the sliding window hit voter checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef SLIDING_WINDOW_HIT_VOTER_TOP_MACROS_SVH
`define SLIDING_WINDOW_HIT_VOTER_TOP_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define SWHV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sliding window hit voter check failed");

// Same-cycle implication built on the macro above.
`define SWHV_ASSERT_IMPL(lbl, ante, cons) \
  `SWHV_ASSERT(lbl, (ante) |-> (cons))

`endif

FILE: rtl/swhv_pkg.sv
// Shared constants for the sliding window hit voter: field widths,
// class, verdict and register codes, and configuration reset values. No dependencies.
package swhv_pkg;

  localparam int KNOWN_DEPTH_DEF   = 4;
  localparam int UNKNOWN_DEPTH_DEF = 8;

  localparam int TIME_W    = 32;
  localparam int CLASS_W   = 2;
  localparam int VERDICT_W = 2;
  localparam int KHITS_W   = 5;
  localparam int UHITS_W   = 7;
  localparam int REG_IDX_W = 2;

  localparam int S_TDATA_W = 2 * TIME_W;
  localparam int M_TDATA_W = VERDICT_W + 2 + KHITS_W + UHITS_W + TIME_W;

  localparam logic [CLASS_W-1:0] CLS_NONE    = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_KNOWN   = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_UNKNOWN = 2'd2;
  localparam logic [CLASS_W-1:0] CLS_DETECT  = 2'd3;

  localparam logic [VERDICT_W-1:0] VERDICT_NONE    = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_KNOWN   = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_UNKNOWN = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_RSVD    = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_KNOWN_WIN   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_UNKNOWN_WIN = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_IDLE_TMO    = 2'd2;

  localparam logic [TIME_W-1:0] KNOWN_WIN_RST   = 32'd3000;
  localparam logic [TIME_W-1:0] UNKNOWN_WIN_RST = 32'd30000;
  localparam logic [TIME_W-1:0] IDLE_TMO_RST    = 32'd5000;

endpackage

FILE: rtl/swhv_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read data holds while the read enable is low. No dependencies.
module swhv_ram #(
  parameter int Width = 32,
  parameter int Depth = 4,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/sliding_window_hit_voter_top.sv
// Sliding window hit voter. A request accepted on s_axis is held in the execute stage,
// then moves to the output register and m_axis. Throughput: one request per cycle
// unless m_axis stalls, set by the single read of each timestamp ring, issued at accept.
// Reset clears counters, flags and last sample time and loads the default windows;
// ring contents are kept, no clearing pass, ready right after reset.
// Uses swhv_pkg and swhv_ram.
module sliding_window_hit_voter_top
  import swhv_pkg::*;
#(
  parameter int KnownDepth   = KNOWN_DEPTH_DEF,
  parameter int UnknownDepth = UNKNOWN_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [31:0] sample_time, [63:32] now_ms
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] face_class
  input  logic [CLASS_W-1:0]   s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [1:0] verdict, [2] window_active, [3] known_locked, [8:4] known_hits,
  // [15:9] unknown_hits, [47:16] unknown_elapsed_ms
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [REG_IDX_W-1:0] cfg_addr_i,
  input  logic [TIME_W-1:0]    cfg_data_i
);

  localparam int KAW = (KnownDepth > 1) ? $clog2(KnownDepth) : 1;
  localparam int UAW = (UnknownDepth > 1) ? $clog2(UnknownDepth) : 1;
  localparam int KCW = $clog2(KnownDepth + 1);
  localparam int UCW = $clog2(UnknownDepth + 1);
  localparam logic [KAW-1:0] KLast = KAW'(KnownDepth - 1);
  localparam logic [UAW-1:0] ULast = UAW'(UnknownDepth - 1);
  localparam logic [KCW-1:0] KFull = KCW'(KnownDepth);
  localparam logic [UCW-1:0] UFull = UCW'(UnknownDepth);

  // configuration
  logic [TIME_W-1:0] known_win_q, unknown_win_q, idle_tmo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_win_q   <= KNOWN_WIN_RST;
      unknown_win_q <= UNKNOWN_WIN_RST;
      idle_tmo_q    <= IDLE_TMO_RST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_KNOWN_WIN:   known_win_q   <= cfg_data_i;
        REG_UNKNOWN_WIN: unknown_win_q <= cfg_data_i;
        REG_IDLE_TMO:    idle_tmo_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // vote state
  logic [KAW-1:0]    khead_q, khead_d;
  logic [KCW-1:0]    kcnt_q, kcnt_d;
  logic [UAW-1:0]    uhead_q, uhead_d;
  logic [UCW-1:0]    ucnt_q, ucnt_d;
  logic [TIME_W-1:0] last_sample_q, last_sample_d;
  logic [TIME_W-1:0] last_face_q, last_face_d;
  logic              active_q, active_d;
  logic              locked_q, locked_d;

  // execute stage: request whose ring data is coming out of the RAMs
  logic              b_valid_q, b_valid_d;
  logic [CLASS_W-1:0] b_cls_q;
  logic [TIME_W-1:0] b_sample_q, b_now_q;
  logic [KAW-1:0]    k_raddr_q;
  logic [UAW-1:0]    u_raddr_q;
  logic              kfwd_q, ufwd_q;
  logic [TIME_W-1:0] kfwd_data_q, ufwd_data_q;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [VERDICT_W-1:0] out_verdict_q;
  logic                 out_active_q, out_locked_q;
  logic [KHITS_W-1:0]   out_khits_q;
  logic [UHITS_W-1:0]   out_uhits_q;
  logic [TIME_W-1:0]    out_elapsed_q;

  logic advance_b, accept;

  assign advance_b     = b_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !b_valid_q || advance_b;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // ring RAMs
  logic              k_we, u_we;
  logic [KAW-1:0]    k_raddr_a;
  logic [UAW-1:0]    u_raddr_a;
  logic [TIME_W-1:0] k_rdata, u_rdata;

  swhv_ram #(.Width(TIME_W), .Depth(KnownDepth)) u_known_ram (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (khead_q),
    .wdata_i (b_now_q),
    .re_i    (accept),
    .raddr_i (k_raddr_a),
    .rdata_o (k_rdata)
  );

  swhv_ram #(.Width(TIME_W), .Depth(UnknownDepth)) u_unknown_ram (
    .clk_i   (clk_i),
    .we_i    (u_we),
    .waddr_i (uhead_q),
    .wdata_i (b_now_q),
    .re_i    (accept),
    .raddr_i (u_raddr_a),
    .rdata_o (u_rdata)
  );

  // execute stage datapath
  logic [KAW-1:0]    khead_inc;
  logic [KCW-1:0]    kcnt_sat;
  logic [UAW-1:0]    uhead_inc;
  logic [UCW-1:0]    ucnt_sat;
  logic [TIME_W-1:0] kstamp, ustamp;
  logic              known_in_win, unk_in_win, idle_hit, u_self;
  logic [VERDICT_W-1:0] verdict;
  logic [TIME_W-1:0] elapsed;

  assign khead_inc = (khead_q == KLast) ? '0 : khead_q + 1'b1;
  assign kcnt_sat  = (kcnt_q == KFull) ? kcnt_q : kcnt_q + 1'b1;
  assign uhead_inc = (uhead_q == ULast) ? '0 : uhead_q + 1'b1;
  assign ucnt_sat  = (ucnt_q == UFull) ? ucnt_q : ucnt_q + 1'b1;

  // a single-entry ring reads back the stamp this request writes
  assign kstamp = (k_raddr_q == khead_q) ? b_now_q : (kfwd_q ? kfwd_data_q : k_rdata);
  assign u_self = (b_cls_q == CLS_UNKNOWN || b_cls_q == CLS_DETECT) &&
                  (b_sample_q != last_sample_q) && (u_raddr_q == uhead_q);
  assign ustamp = u_self ? b_now_q : (ufwd_q ? ufwd_data_q : u_rdata);

  assign known_in_win = (b_now_q - kstamp) <= known_win_q;
  assign unk_in_win   = (b_now_q - ustamp) <= unknown_win_q;
  assign idle_hit     = (b_now_q - last_face_q) >= idle_tmo_q;

  always_comb begin
    khead_d       = khead_q;
    kcnt_d        = kcnt_q;
    uhead_d       = uhead_q;
    ucnt_d        = ucnt_q;
    last_sample_d = last_sample_q;
    last_face_d   = last_face_q;
    active_d      = active_q;
    locked_d      = locked_q;
    k_we          = 1'b0;
    u_we          = 1'b0;
    verdict       = VERDICT_NONE;
    if (advance_b && (b_sample_q != last_sample_q)) begin
      last_sample_d = b_sample_q;
      case (b_cls_q)
        CLS_NONE: begin
          if (active_q && idle_hit) begin
            khead_d     = '0;
            kcnt_d      = '0;
            uhead_d     = '0;
            ucnt_d      = '0;
            last_face_d = '0;
            active_d    = 1'b0;
            locked_d    = 1'b0;
          end
        end
        CLS_KNOWN: begin
          last_face_d = b_now_q;
          active_d    = 1'b1;
          if (locked_q) begin
            uhead_d = '0;
            ucnt_d  = '0;
          end else begin
            k_we    = 1'b1;
            khead_d = khead_inc;
            kcnt_d  = kcnt_sat;
            if ((kcnt_sat == KFull) && known_in_win) begin
              locked_d = 1'b1;
              uhead_d  = '0;
              ucnt_d   = '0;
              verdict  = VERDICT_KNOWN;
            end
          end
        end
        CLS_UNKNOWN, CLS_DETECT: begin
          last_face_d = b_now_q;
          active_d    = 1'b1;
          u_we        = 1'b1;
          uhead_d     = uhead_inc;
          ucnt_d      = ucnt_sat;
          if ((ucnt_sat == UFull) && unk_in_win) begin
            khead_d     = '0;
            kcnt_d      = '0;
            uhead_d     = '0;
            ucnt_d      = '0;
            last_face_d = '0;
            active_d    = 1'b0;
            locked_d    = 1'b0;
            verdict     = VERDICT_UNKNOWN;
          end
        end
        default: ;
      endcase
    end
  end

  assign elapsed = (ucnt_d != '0) ? (b_now_q - ustamp) : '0;

  // accept side: read addresses follow the state this request will see
  logic [CLASS_W-1:0] cls_a;
  logic [TIME_W-1:0]  sample_a, now_a;
  logic               unk_a;
  logic [UAW-1:0]     uhead_d_inc;

  assign cls_a       = s_axis_tuser;
  assign sample_a    = s_axis_tdata[TIME_W-1:0];
  assign now_a       = s_axis_tdata[2*TIME_W-1:TIME_W];
  assign unk_a       = (sample_a != last_sample_d) &&
                       (cls_a == CLS_UNKNOWN || cls_a == CLS_DETECT);
  assign uhead_d_inc = (uhead_d == ULast) ? '0 : uhead_d + 1'b1;
  assign k_raddr_a   = (khead_d == KLast) ? '0 : khead_d + 1'b1;

  always_comb begin
    if (unk_a) begin
      // ring full after the write, or about to become full: oldest is next head
      if ((ucnt_d == UFull) || (ucnt_d + 1'b1 == UFull)) begin
        u_raddr_a = uhead_d_inc;
      end else begin
        u_raddr_a = '0;
      end
    end else begin
      u_raddr_a = (ucnt_d == UFull) ? uhead_d : '0;
    end
  end

  assign b_valid_d = accept ? 1'b1 : (advance_b ? 1'b0 : b_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      khead_q       <= '0;
      kcnt_q        <= '0;
      uhead_q       <= '0;
      ucnt_q        <= '0;
      last_sample_q <= '0;
      last_face_q   <= '0;
      active_q      <= 1'b0;
      locked_q      <= 1'b0;
      b_valid_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      khead_q       <= khead_d;
      kcnt_q        <= kcnt_d;
      uhead_q       <= uhead_d;
      ucnt_q        <= ucnt_d;
      last_sample_q <= last_sample_d;
      last_face_q   <= last_face_d;
      active_q      <= active_d;
      locked_q      <= locked_d;
      b_valid_q     <= b_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_comb begin
    if (advance_b) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_cls_q     <= cls_a;
      b_sample_q  <= sample_a;
      b_now_q     <= now_a;
      k_raddr_q   <= k_raddr_a;
      u_raddr_q   <= u_raddr_a;
      // bypass the write that lands on the same edge as this read
      kfwd_q      <= k_we && (khead_q == k_raddr_a);
      ufwd_q      <= u_we && (uhead_q == u_raddr_a);
      kfwd_data_q <= b_now_q;
      ufwd_data_q <= b_now_q;
    end
    if (advance_b) begin
      out_verdict_q <= verdict;
      out_active_q  <= active_d;
      out_locked_q  <= locked_d;
      out_khits_q   <= KHITS_W'(kcnt_d);
      out_uhits_q   <= UHITS_W'(ucnt_d);
      out_elapsed_q <= elapsed;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_elapsed_q, out_uhits_q, out_khits_q,
                          out_locked_q, out_active_q, out_verdict_q};

endmodule

FILE: rtl/swhv_checker.sv
// Port-level checks for the sliding window hit voter, bound to the top level.
// Uses swhv_pkg and sliding_window_hit_voter_top_macros.svh.
`include "sliding_window_hit_voter_top_macros.svh"

module swhv_checker
  import swhv_pkg::*;
#(
  parameter int KnownDepth   = KNOWN_DEPTH_DEF,
  parameter int UnknownDepth = UNKNOWN_DEPTH_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic [VERDICT_W-1:0] verdict;
  logic [KHITS_W-1:0]   khits;
  logic [UHITS_W-1:0]   uhits;
  logic                 locked;
  logic                 stalled;
  logic                 hits_in_range;
  logic                 known_status_ok;

  assign verdict = m_axis_tdata[1:0];
  assign locked  = m_axis_tdata[3];
  assign khits   = m_axis_tdata[8:4];
  assign uhits   = m_axis_tdata[15:9];

  assign stalled         = m_axis_tvalid && !m_axis_tready;
  assign hits_in_range   = (khits <= KHITS_W'(KnownDepth)) && (uhits <= UHITS_W'(UnknownDepth));
  assign known_status_ok = locked && (uhits == '0) && (khits == KHITS_W'(KnownDepth));

  // hold a stalled result
  `SWHV_ASSERT(a_out_hold, stalled |=> m_axis_tvalid && $stable(m_axis_tdata))

  `SWHV_ASSERT_IMPL(a_hits_bound, m_axis_tvalid, hits_in_range)

  // unknown confirmation reports fully cleared status
  `SWHV_ASSERT_IMPL(a_unknown_clears, m_axis_tvalid && (verdict == VERDICT_UNKNOWN), m_axis_tdata[M_TDATA_W-1:2] == '0)

  // known confirmation locks, reports a full known ring and empties the unknown ring
  `SWHV_ASSERT_IMPL(a_known_locks, m_axis_tvalid && (verdict == VERDICT_KNOWN), known_status_ok)

  `SWHV_ASSERT_IMPL(a_no_rsvd, m_axis_tvalid, verdict != VERDICT_RSVD)

endmodule

bind sliding_window_hit_voter_top swhv_checker #(
  .KnownDepth   (KnownDepth),
  .UnknownDepth (UnknownDepth)
) u_swhv_checker (.*);
